// ===== rtl/core/bfti_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear force table interpolator package
// Shared widths, payload structs and controller-to-datapath command type.
// ---------------------------------------------------------------------------
package bfti_pkg;

   // Grid geometry and number formats
   localparam int GRID_SIZE    = 16;
   localparam int GRID_BITS    = $clog2(GRID_SIZE);
   localparam int DEPTH        = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W       = 2 * GRID_BITS;
   localparam int FRAC_BITS    = 8;
   localparam int FORCE_WIDTH  = 16;

   // Field widths of the ports
   localparam int ENTRY_IDX_W  = 4;
   localparam int IN_FORCE_W   = 16;
   localparam int OUT_FORCE_W  = 16;
   localparam int QUERY_W      = 12;
   localparam int QUERY_INT_W  = QUERY_W - FRAC_BITS;
   localparam int CIDX_W       = QUERY_INT_W + 1;

   // Datapath widths
   localparam int LANES        = 3;
   localparam int ENTRY_W      = LANES * FORCE_WIDTH;
   localparam int WFAC_W       = FRAC_BITS + 1;
   localparam int WT_W         = 2 * FRAC_BITS + 1;
   localparam int PROD_W       = FORCE_WIDTH + WT_W + 1;

   // Operation codes
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   typedef struct packed {
      logic                          operation;
      logic [ENTRY_IDX_W-1:0]        entry_angle_index;
      logic [ENTRY_IDX_W-1:0]        entry_speed_index;
      logic signed [IN_FORCE_W-1:0]  entry_force_x;
      logic signed [IN_FORCE_W-1:0]  entry_force_y;
      logic signed [IN_FORCE_W-1:0]  entry_force_z;
      logic [QUERY_W-1:0]            query_angle;
      logic [QUERY_W-1:0]            query_speed;
   } req_type;

   typedef struct packed {
      logic signed [OUT_FORCE_W-1:0] force_x;
      logic signed [OUT_FORCE_W-1:0] force_y;
      logic signed [OUT_FORCE_W-1:0] force_z;
   } rsp_type;

   typedef struct packed {
      logic       load;       // capture query point
      logic       wr_en;      // store one table entry
      logic       rd_en;      // read one corner
      logic [1:0] corner;     // bit 0: angle + 1, bit 1: speed + 1
      logic       mul_en;     // weight the corner read last cycle
      logic       acc_en;     // add weighted corner into accumulator
      logic       acc_first;  // first add of a query: overwrite
   } cmd_type;

endpackage

// ===== rtl/core/bilinear_force_table_interpolator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear force table interpolator
// 16 x 16 grid of three-component force vectors; table write and bilinear
// query of the four surrounding grid entries with floor rounding.
// ---------------------------------------------------------------------------
//
//  channel   handshake               payload            transfer when
//  -------   ---------------------   ----------------   ----------------------
//  request   start / busy            req_data (struct)  start && !busy
//  result    rsp_strobe (1 cycle)    rsp_data (struct)  rsp_strobe, no stall
//
//  A table write is a single-cycle transfer and gives no result; busy stays
//  low, so writes can follow each other every cycle.
//  A query holds busy while the single-port table gives one corner per
//  cycle (four reads) and the multiply and accumulate stages drain. The
//  result strobe comes as busy falls, when a new request may already be
//  taken, so a new query is only taken once the last one is through.
//  Synchronous reset returns the controller to idle and clears all 256 entry
//  valid bits at once; an entry never written reads as zero. No clearing pass.
//  The result side cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module bilinear_force_table_interpolator_unit
   import bfti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // Commands from sequencer to datapath
   cmd_type cmd;

   // Controller: decode the operation, step through the corners
   bfti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .operation  (req_data.operation),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Datapath: table, weights, multiply-accumulate per component
   bfti_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/bfti_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear force table interpolator controller
// Sequences the four corner reads, weighting and accumulation of a query, and issues table writes.
// ---------------------------------------------------------------------------
module bfti_ctrl
   import bfti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    operation,
   output logic    busy,
   output logic    rsp_strobe,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_QUERY = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   localparam logic [2:0] CNT_LAST_RD  = 3'd3;
   localparam logic [2:0] CNT_FIRST_AC = 3'd2;
   localparam logic [2:0] CNT_LAST     = 3'd5;

   logic [1:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       accept;

   assign busy       = (state_ff == ST_QUERY);
   assign accept     = start && !busy;
   assign rsp_strobe = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            cnt_in = '0;
            if (accept && operation == OP_QUERY) begin
               state_in = ST_QUERY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = accept && (operation == OP_QUERY);
      cmd.wr_en     = accept && (operation == OP_WRITE);
      cmd.corner    = cnt_ff[1:0];
      if (state_ff == ST_QUERY) begin
         cmd.rd_en     = (cnt_ff <= CNT_LAST_RD);
         cmd.mul_en    = cnt_ff inside {[3'd1:3'd4]};
         cmd.acc_en    = cnt_ff inside {[CNT_FIRST_AC:CNT_LAST]};
         cmd.acc_first = (cnt_ff == CNT_FIRST_AC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // A query that is taken must leave the idle side at the next edge
   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && operation == OP_QUERY) |=> busy)
      else $error("query accepted but controller not busy");

   // The last accumulate step is followed by exactly one result strobe
   a_last_acc_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY && cnt_ff == CNT_LAST) |=> (rsp_strobe && !busy))
      else $error("result strobe missing after final accumulate");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Table writes never collide with corner reads on the single port
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.rd_en))
      else $error("table write and read in the same cycle");

endmodule

// ===== rtl/core/bfti_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear force table interpolator datapath
// Force table memory, corner read, weight multiply and accumulation.
// ---------------------------------------------------------------------------
module bfti_datapath
   import bfti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   // Table storage, valid bit per entry stands for the zero reset value
   logic [ENTRY_W-1:0] force_mem_ff [DEPTH];
   logic [DEPTH-1:0]   vld_ff;

   // Captured query point
   logic [QUERY_W-1:0] qa_ff, qs_ff;

   // Read stage
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               hit_ff;
   logic [WT_W-1:0]    wt_ff;

   // Multiply and accumulate stages
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PROD_W-1:0] acc_ff  [LANES];

   // Write decode
   logic               wr_in_grid;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_entry;

   // Corner decode
   logic [CIDX_W-1:0]   ca, cs;
   logic                c_in_grid;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WFAC_W-1:0]   fa, fs, wa, ws;
   logic [2*WFAC_W-1:0] wt_full;

   always_comb begin
      wr_in_grid =
         ({1'b0, req_data.entry_angle_index} < (ENTRY_IDX_W+1)'(GRID_SIZE)) &&
         ({1'b0, req_data.entry_speed_index} < (ENTRY_IDX_W+1)'(GRID_SIZE));
      wr_addr  = {req_data.entry_angle_index[GRID_BITS-1:0],
                  req_data.entry_speed_index[GRID_BITS-1:0]};
      // keep the low FORCE_WIDTH bits of each component
      wr_entry = {req_data.entry_force_z[FORCE_WIDTH-1:0],
                  req_data.entry_force_y[FORCE_WIDTH-1:0],
                  req_data.entry_force_x[FORCE_WIDTH-1:0]};
   end

   always_comb begin
      ca = {1'b0, qa_ff[QUERY_W-1:FRAC_BITS]} + CIDX_W'(cmd.corner[0]);
      cs = {1'b0, qs_ff[QUERY_W-1:FRAC_BITS]} + CIDX_W'(cmd.corner[1]);
      c_in_grid = (ca < CIDX_W'(GRID_SIZE)) && (cs < CIDX_W'(GRID_SIZE));
      rd_addr   = {ca[GRID_BITS-1:0], cs[GRID_BITS-1:0]};
      fa = {1'b0, qa_ff[FRAC_BITS-1:0]};
      fs = {1'b0, qs_ff[FRAC_BITS-1:0]};
      wa = cmd.corner[0] ? fa : (WFAC_W'(1 << FRAC_BITS) - fa);
      ws = cmd.corner[1] ? fs : (WFAC_W'(1 << FRAC_BITS) - fs);
      wt_full = (2*WFAC_W)'(wa) * (2*WFAC_W)'(ws);
   end

   // Memory: one port, write on a table transfer, read during a query
   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_grid) begin
         force_mem_ff[wr_addr] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= force_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.wr_en && wr_in_grid) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qa_ff <= req_data.query_angle;
         qs_ff <= req_data.query_speed;
      end
      if (cmd.rd_en) begin
         hit_ff <= c_in_grid && vld_ff[rd_addr];
         wt_ff  <= wt_full[WT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < LANES; c++) begin
         if (cmd.mul_en) begin
            prod_ff[c] <= PROD_W'(hit_ff
               ? $signed(rd_data_ff[c*FORCE_WIDTH +: FORCE_WIDTH])
               : $signed({FORCE_WIDTH{1'b0}})) * PROD_W'($signed({1'b0, wt_ff}));
         end
         if (cmd.acc_en) begin
            acc_ff[c] <= cmd.acc_first ? prod_ff[c] : (acc_ff[c] + prod_ff[c]);
         end
      end
   end

   // Floor shift by 2*FRAC_BITS, keep the low result bits
   assign rsp_data.force_x = acc_ff[0][2*FRAC_BITS +: OUT_FORCE_W];
   assign rsp_data.force_y = acc_ff[1][2*FRAC_BITS +: OUT_FORCE_W];
   assign rsp_data.force_z = acc_ff[2][2*FRAC_BITS +: OUT_FORCE_W];

endmodule

// ===== bench/tb_bilinear_force_table_interpolator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear force table interpolator testbench
// Drives table writes and bilinear queries through the start/busy command
// port with random idle gaps. A behavioral copy of the force grid predicts
// every query result, and each strobed result is compared per component,
// in order, with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_bilinear_force_table_interpolator_unit;
   import bfti_pkg::*;

   // Clock period in ns, settle cycles after the last result, run limit in ns
   localparam int      CLK_PERIOD   = 8;
   localparam int      RESET_CYCLES = 12;
   localparam int      DRAIN_CYCLES = 12;
   localparam longint  RUN_LIMIT_NS = 2_000_000;
   localparam int      FRAC_ONE     = 1 << FRAC_BITS;
   localparam int      RANDOM_ITEMS = 450;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Predicted force grid and the queue of results still owed by the block
   logic signed [FORCE_WIDTH-1:0] grid_force [DEPTH][LANES];
   rsp_type                       expected_forces [$];

   int error_count;
   bit gaps_on;

   bilinear_force_table_interpolator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop: a hung handshake or a lost result ends up here
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_bilinear_force_table_interpolator_unit: errors");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Prediction
   // -----------------------------------------------------------------------

   // Weight the four corners around the query point and floor-shift the sum.
   // A corner whose index runs past the grid edge contributes zero.
   function automatic rsp_type interpolate_force(input logic [QUERY_W-1:0] angle,
                                                 input logic [QUERY_W-1:0] speed);
      int     a0;
      int     s0;
      int     fa;
      int     fs;
      int     ca;
      int     cs;
      longint weight [4];
      longint lane_sum [LANES];
      rsp_type res;
      a0 = int'(angle >> FRAC_BITS);
      s0 = int'(speed >> FRAC_BITS);
      fa = int'(angle) & (FRAC_ONE - 1);
      fs = int'(speed) & (FRAC_ONE - 1);
      weight[0] = longint'((FRAC_ONE - fa) * (FRAC_ONE - fs));
      weight[1] = longint'(fa * (FRAC_ONE - fs));
      weight[2] = longint'((FRAC_ONE - fa) * fs);
      weight[3] = longint'(fa * fs);
      for (int lane = 0; lane < LANES; lane++) begin
         lane_sum[lane] = 0;
         for (int k = 0; k < 4; k++) begin
            // bit 0 of k steps the angle, bit 1 the speed
            ca = a0 + (k & 1);
            cs = s0 + (k >> 1);
            if (ca < GRID_SIZE && cs < GRID_SIZE) begin
               lane_sum[lane] += longint'(grid_force[ca * GRID_SIZE + cs][lane]) * weight[k];
            end
         end
         lane_sum[lane] = lane_sum[lane] >>> (2 * FRAC_BITS);
      end
      res.force_x = lane_sum[0][OUT_FORCE_W-1:0];
      res.force_y = lane_sum[1][OUT_FORCE_W-1:0];
      res.force_z = lane_sum[2][OUT_FORCE_W-1:0];
      return res;
   endfunction

   // Apply one accepted transfer to the predicted grid, in acceptance order
   function automatic void update_force_model(input req_type item);
      int idx;
      if (item.operation == OP_WRITE) begin
         // drop writes whose index lies outside the grid
         if (item.entry_angle_index < GRID_SIZE && item.entry_speed_index < GRID_SIZE) begin
            idx = int'(item.entry_angle_index) * GRID_SIZE + int'(item.entry_speed_index);
            grid_force[idx][0] = item.entry_force_x;
            grid_force[idx][1] = item.entry_force_y;
            grid_force[idx][2] = item.entry_force_z;
         end
      end else begin
         expected_forces.push_back(interpolate_force(item.query_angle, item.query_speed));
      end
   endfunction

   // -----------------------------------------------------------------------
   // Result checking: the result side cannot stall, so sample every strobe
   // -----------------------------------------------------------------------

   function automatic void check_field(input string name,
                                       input logic signed [OUT_FORCE_W-1:0] exp_val,
                                       input logic signed [OUT_FORCE_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_forces.size() == 0) begin
            $error("result with no query outstanding: %h", rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_forces.pop_front();
            check_field("force_x", exp_rsp.force_x, rsp_data.force_x);
            check_field("force_y", exp_rsp.force_y, rsp_data.force_y);
            check_field("force_z", exp_rsp.force_z, rsp_data.force_z);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus helpers
   // -----------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Lean on the extremes of the signed range
   function automatic logic signed [IN_FORCE_W-1:0] rand_force();
      case ($urandom_range(0, 7))
         0: begin
            return 16'sh7FFF;
         end
         1: begin
            return 16'sh8000;
         end
         2: begin
            return '0;
         end
         default: begin
            return IN_FORCE_W'($urandom);
         end
      endcase
   endfunction

   // Fields that the operation ignores carry random noise
   function automatic req_type make_write(input int angle_idx, input int speed_idx,
                                          input logic signed [IN_FORCE_W-1:0] fx,
                                          input logic signed [IN_FORCE_W-1:0] fy,
                                          input logic signed [IN_FORCE_W-1:0] fz);
      req_type item;
      item.operation         = OP_WRITE;
      item.entry_angle_index = angle_idx[ENTRY_IDX_W-1:0];
      item.entry_speed_index = speed_idx[ENTRY_IDX_W-1:0];
      item.entry_force_x     = fx;
      item.entry_force_y     = fy;
      item.entry_force_z     = fz;
      item.query_angle       = QUERY_W'($urandom);
      item.query_speed       = QUERY_W'($urandom);
      return item;
   endfunction

   function automatic req_type make_query(input int angle, input int speed);
      req_type item;
      item.operation         = OP_QUERY;
      item.entry_angle_index = ENTRY_IDX_W'($urandom);
      item.entry_speed_index = ENTRY_IDX_W'($urandom);
      item.entry_force_x     = IN_FORCE_W'($urandom);
      item.entry_force_y     = IN_FORCE_W'($urandom);
      item.entry_force_z     = IN_FORCE_W'($urandom);
      item.query_angle       = angle[QUERY_W-1:0];
      item.query_speed       = speed[QUERY_W-1:0];
      return item;
   endfunction

   // Present one item and hold it until the block takes it. Start stays high
   // after the transfer so that the next item can follow with no gap; it is
   // lowered only when an idle gap comes.
   task automatic send_item(input req_type item);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      update_force_model(item);
   endtask

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // Every entry is cleared by reset, including the grid corners
   task automatic test_cleared_table();
      send_item(make_query(0, 0));
      send_item(make_query(12'hFFF, 12'hFFF));
      send_item(make_query(12'h780, 12'h340));
   endtask

   // Extreme values at the grid corners; integer points, full fractions,
   // and corners past the grid edge on either axis
   task automatic test_grid_extremes();
      send_item(make_write(0, 0, 16'sh7FFF, 16'sh8000, -16'sd1));
      send_item(make_write(1, 0, 16'sh8000, 16'sh7FFF, 16'sd1));
      send_item(make_write(0, 1, 16'sh7FFF, 16'sh7FFF, 16'sh8000));
      send_item(make_write(1, 1, 16'sh8000, 16'sh8000, 16'sh7FFF));
      send_item(make_write(15, 15, 16'sh7FFF, 16'sh8000, 16'sh5555));
      send_item(make_write(15, 0, 16'shAAAA, 16'sh7FFF, 16'sh8000));
      send_item(make_write(0, 15, 16'sh8000, 16'shAAAA, 16'sh7FFF));
      send_item(make_query(12'h000, 12'h000));   // integer point: near corner
      send_item(make_query(12'h0FF, 12'h0FF));   // largest fractions
      send_item(make_query(12'h080, 12'h080));
      send_item(make_query(12'hF00, 12'hF00));   // integer point at far corner
      send_item(make_query(12'hFFF, 12'hFFF));   // three corners past the edge
      send_item(make_query(12'hF80, 12'h000));   // angle runs past the edge
      send_item(make_query(12'h000, 12'hF80));   // speed runs past the edge
      // overwrite an entry and read it back
      send_item(make_write(0, 0, -16'sd2, 16'sd3, 16'sh7FFF));
      send_item(make_query(12'h040, 12'h0C0));
   endtask

   // Query the point just written with no idle cycle in between
   task automatic test_write_then_query();
      int ai;
      int si;
      gaps_on = 1'b0;
      repeat (3) begin
         ai = $urandom_range(0, GRID_SIZE - 1);
         si = $urandom_range(0, GRID_SIZE - 1);
         send_item(make_write(ai, si, rand_force(), rand_force(), rand_force()));
         send_item(make_query((ai << FRAC_BITS) | $urandom_range(0, FRAC_ONE - 1),
                              (si << FRAC_BITS) | $urandom_range(0, FRAC_ONE - 1)));
      end
      gaps_on = 1'b1;
   endtask

   // Random mix of writes and queries; each run of items picks at random
   // between random idling and dense back-to-back traffic
   task automatic test_random_traffic();
      int qa;
      int qs;
      for (int sent = 0; sent < RANDOM_ITEMS; sent += 25) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (25) begin
            if ($urandom_range(0, 99) < 45) begin
               send_item(make_write($urandom_range(0, GRID_SIZE - 1),
                                    $urandom_range(0, GRID_SIZE - 1),
                                    rand_force(), rand_force(), rand_force()));
            end else begin
               qa = $urandom_range(0, (1 << QUERY_W) - 1);
               qs = $urandom_range(0, (1 << QUERY_W) - 1);
               // snap to a grid point now and then
               if ($urandom_range(0, 7) == 0) qa &= ~(FRAC_ONE - 1);
               if ($urandom_range(0, 7) == 0) qs &= ~(FRAC_ONE - 1);
               send_item(make_query(qa, qs));
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------

   initial begin
      error_count = 0;
      gaps_on     = 1'b1;
      for (int idx = 0; idx < DEPTH; idx++) begin
         for (int lane = 0; lane < LANES; lane++) grid_force[idx][lane] = '0;
      end

      // Hold reset for a fixed number of edges; never assert it again
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_cleared_table();
      test_grid_extremes();
      test_write_then_query();
      test_random_traffic();

      // Drop start, wait for every owed result, then let the pipe settle
      start <= 1'b0;
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_bilinear_force_table_interpolator_unit: clean");
      end else begin
         $display("tb_bilinear_force_table_interpolator_unit: errors");
      end
      $finish;
   end

endmodule
